FILE: hdl/fsap_pkg.sv
// Shared constants and types for the farthest pair and apex search.
// No dependencies; every other file refers to it by scoped names.
package fsap_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 2 * COORD_W;
    localparam int OP_W       = COORD_W + 1;
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int ROLE_W     = 2;

    localparam logic [ROLE_W-1:0] ROLE_A    = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_B    = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_APEX = 2'd2;

    // point store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [PT_W-1:0]  data;
    } t_wr;

    // one search job handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             few;
    } t_job;

endpackage

FILE: hdl/farthest_pair_and_apex.sv
// Top level: loader, job queue, point store and search engine.
// Depends on fsap_pkg, fsap_front, fsap_jobq, fsap_store, fsap_back.
//
//  channel | valid        | stall        | words
//  --------+--------------+--------------+------------------------------------------
//  in      | i_in_valid   | o_in_stall   | x, y, final flag; one point per word
//  out     | o_out_valid  | i_out_stall  | role, index, x, y, too_few, last_result
//
// Points load at one word per cycle. After the final word the input stalls while the
// search runs, one pair or one apex candidate per cycle through the single store read
// port, then through the pipeline drains and the result words. Sets under three points
// skip the search. Reset is synchronous, active low; the store itself is not cleared.
// An output stall only holds the result register and pauses emission.
module farthest_pair_and_apex (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fsap_pkg::COORD_W-1:0] i_x_coord,
    input  logic [fsap_pkg::COORD_W-1:0] i_y_coord,
    input  logic                         i_final_point,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fsap_pkg::ROLE_W-1:0]  o_role,
    output logic [fsap_pkg::IDX_W-1:0]   o_point_index,
    output logic [fsap_pkg::COORD_W-1:0] o_out_x,
    output logic [fsap_pkg::COORD_W-1:0] o_out_y,
    output logic                         o_too_few,
    output logic                         o_last_result
);

    fsap_pkg::t_wr              w_wr;
    fsap_pkg::t_job             w_push_job;
    fsap_pkg::t_job             w_pop_job;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_job_valid;
    logic                       w_done;
    logic [fsap_pkg::IDX_W-1:0] w_rd_addr;
    logic [fsap_pkg::PT_W-1:0]  w_rd_data;

    fsap_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_final_point (i_final_point),
        .i_done        (w_done),
        .o_wr          (w_wr),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    fsap_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_pop_job)
    );

    fsap_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    fsap_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_done        (w_done),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_role        (o_role),
        .o_point_index (o_point_index),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_too_few     (o_too_few),
        .o_last_result (o_last_result)
    );

endmodule

FILE: hdl/fsap_store.sv
// Point store: one write port, one read port with registered read data.
// Depends on fsap_pkg.
module fsap_store (
    input  logic                       i_clk,
    input  fsap_pkg::t_wr              i_wr,
    input  logic [fsap_pkg::IDX_W-1:0] i_rd_addr,
    output logic [fsap_pkg::PT_W-1:0]  o_rd_data
);

    logic [fsap_pkg::PT_W-1:0] r_mem [fsap_pkg::MAX_POINTS];
    logic [fsap_pkg::PT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/fsap_jobq.sv
// Two-entry job queue between the loader and the search engine.
// Depends on fsap_pkg.
module fsap_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fsap_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output fsap_pkg::t_job o_job
);

    fsap_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

FILE: hdl/fsap_front.sv
// Loader: accepts point words, writes them to the store, queues a job on the final one.
// Depends on fsap_pkg.
module fsap_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fsap_pkg::COORD_W-1:0] i_x_coord,
    input  logic [fsap_pkg::COORD_W-1:0] i_y_coord,
    input  logic                         i_final_point,
    input  logic                         i_done,
    output fsap_pkg::t_wr                o_wr,
    output logic                         o_push,
    output fsap_pkg::t_job               o_job
);

    logic [fsap_pkg::CNT_W-1:0] r_count;
    logic [fsap_pkg::CNT_W-1:0] n_count;
    logic                       r_wait;
    logic                       w_accept;
    logic                       w_room;

    assign w_accept = i_in_valid && !r_wait;
    assign w_room   = (r_count < fsap_pkg::CNT_W'(fsap_pkg::MAX_POINTS));
    assign n_count  = w_room ? r_count + fsap_pkg::CNT_W'(1) : r_count;

    assign o_wr.en   = w_accept && w_room;
    assign o_wr.addr = r_count[fsap_pkg::IDX_W-1:0];
    assign o_wr.data = {i_x_coord, i_y_coord};

    assign o_push    = w_accept && i_final_point;
    assign o_job.count = n_count;
    assign o_job.few   = (n_count < fsap_pkg::CNT_W'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wait  <= 1'b0;
        end else begin
            if (w_accept) begin
                // hold off new points until the back end has finished with the set
                if (i_final_point) begin
                    r_count <= '0;
                    r_wait  <= 1'b1;
                end else begin
                    r_count <= n_count;
                end
            end else if (i_done) begin
                r_wait <= 1'b0;
            end
        end
    end

    assign o_in_stall = r_wait;

endmodule

FILE: hdl/fsap_back.sv
// Search engine: pair scan, apex scan and result emission over the point store.
// Depends on fsap_pkg; reads the store through a registered read port.
module fsap_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  fsap_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic [fsap_pkg::IDX_W-1:0]   o_rd_addr,
    input  logic [fsap_pkg::PT_W-1:0]    i_rd_data,
    output logic                         o_done,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fsap_pkg::ROLE_W-1:0]  o_role,
    output logic [fsap_pkg::IDX_W-1:0]   o_point_index,
    output logic [fsap_pkg::COORD_W-1:0] o_out_x,
    output logic [fsap_pkg::COORD_W-1:0] o_out_y,
    output logic                         o_too_few,
    output logic                         o_last_result
);

    localparam int CW = fsap_pkg::COORD_W;
    localparam int IW = fsap_pkg::IDX_W;
    localparam int NW = fsap_pkg::CNT_W;
    localparam int OW = fsap_pkg::OP_W;
    localparam int PW = fsap_pkg::PROD_W;
    localparam int AW = fsap_pkg::ACC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ISSI, S_GETI, S_PAIR, S_PDRAIN,
        S_GETA, S_GETB, S_APEX, S_ADRAIN, S_ERD, S_EOUT
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [NW-1:0]              r_n;
    logic                       r_few;
    logic [IW-1:0]              r_i;
    logic [IW-1:0]              r_j;
    logic [IW-1:0]              r_idx [3];
    logic [fsap_pkg::ROLE_W-1:0] r_k;
    logic [AW-1:0]              r_best;
    logic [fsap_pkg::PT_W-1:0]  r_pi;
    logic [fsap_pkg::PT_W-1:0]  r_a;
    logic [fsap_pkg::PT_W-1:0]  r_b;

    // pipeline: read in flight, operands, products, value
    logic          r_v0, r_v1, r_v2, r_v3;
    logic          r_m0, r_m1, r_m2, r_m3;
    logic [IW-1:0] r_i0, r_i1, r_i2, r_i3;
    logic [IW-1:0] r_j0, r_j1, r_j2, r_j3;
    logic          r_s1, r_s2, r_s3;
    logic signed [OW-1:0] r_a1, r_b1, r_a2, r_b2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic [AW-1:0]        r_val3;

    logic                       r_ov;
    logic [fsap_pkg::ROLE_W-1:0] r_o_role;
    logic [IW-1:0]              r_o_idx;
    logic [CW-1:0]              r_o_x;
    logic [CW-1:0]              r_o_y;
    logic                       r_o_few;
    logic                       r_o_last;
    logic                       r_done;

    logic                 w_pipe_busy;
    logic                 w_last_j;
    logic                 w_last_pi;
    logic                 w_last_ai;
    logic                 w_out_free;
    logic                 w_issue;
    logic signed [OW-1:0] w_px, w_py, w_ix, w_iy, w_ax, w_ay, w_bx, w_by;
    logic signed [OW-1:0] w_a1, w_b1, w_a2, w_b2;
    logic signed [AW-1:0] w_sum;
    logic [AW-1:0]        w_val;
    logic                 w_in_set;

    assign w_pipe_busy = r_v0 || r_v1 || r_v2 || r_v3;
    assign w_last_j    = ({1'b0, r_j} == r_n - NW'(1));
    assign w_last_pi   = ({1'b0, r_i} == r_n - NW'(2));
    assign w_last_ai   = ({1'b0, r_i} == r_n - NW'(1));
    assign w_out_free  = !r_ov || !i_out_stall;
    assign w_issue     = (r_state == S_PAIR) || (r_state == S_APEX);
    assign o_pop       = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        case (r_state)
            S_ISSI:   o_rd_addr = r_i;
            S_PAIR:   o_rd_addr = r_j;
            S_PDRAIN: o_rd_addr = r_idx[0];
            S_GETA:   o_rd_addr = r_idx[1];
            S_APEX:   o_rd_addr = r_i;
            S_ERD:    o_rd_addr = r_idx[r_k];
            S_EOUT:   o_rd_addr = r_idx[r_k];
            default:  o_rd_addr = r_i;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.few ? S_ERD : S_ISSI;
                end
            end
            S_ISSI:   n_state = S_GETI;
            S_GETI:   n_state = S_PAIR;
            S_PAIR: begin
                if (w_last_j) begin
                    n_state = w_last_pi ? S_PDRAIN : S_ISSI;
                end
            end
            S_PDRAIN: n_state = w_pipe_busy ? S_PDRAIN : S_GETA;
            S_GETA:   n_state = S_GETB;
            S_GETB:   n_state = S_APEX;
            S_APEX:   n_state = w_last_ai ? S_ADRAIN : S_APEX;
            S_ADRAIN: n_state = w_pipe_busy ? S_ADRAIN : S_ERD;
            S_ERD:    n_state = S_EOUT;
            S_EOUT: begin
                if (w_out_free) begin
                    n_state = (r_k == fsap_pkg::ROLE_APEX) ? S_IDLE : S_ERD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // operand stage
    assign w_px = OW'($signed(i_rd_data[2*CW-1:CW]));
    assign w_py = OW'($signed(i_rd_data[CW-1:0]));
    assign w_ix = OW'($signed(r_pi[2*CW-1:CW]));
    assign w_iy = OW'($signed(r_pi[CW-1:0]));
    assign w_ax = OW'($signed(r_a[2*CW-1:CW]));
    assign w_ay = OW'($signed(r_a[CW-1:0]));
    assign w_bx = OW'($signed(r_b[2*CW-1:CW]));
    assign w_by = OW'($signed(r_b[CW-1:0]));

    always_comb begin
        if (r_m0) begin
            w_a1 = w_bx - w_ax;
            w_b1 = w_py - w_ay;
            w_a2 = w_by - w_ay;
            w_b2 = w_px - w_ax;
        end else begin
            w_a1 = w_ix - w_px;
            w_b1 = w_ix - w_px;
            w_a2 = w_iy - w_py;
            w_b2 = w_iy - w_py;
        end
    end

    // value stage: squared distance or absolute cross product
    assign w_sum = r_m2 ? (AW'(r_p1) - AW'(r_p2)) : (AW'(r_p1) + AW'(r_p2));
    assign w_val = w_sum[AW-1] ? AW'(-w_sum) : AW'(w_sum);

    assign w_in_set = ({1'b0, r_idx[r_k]} < r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ov    <= 1'b0;
            r_done  <= 1'b0;
            r_n     <= '0;
            r_k     <= fsap_pkg::ROLE_A;
            r_best  <= '0;
            r_idx[0] <= IW'(0);
            r_idx[1] <= IW'(1);
            r_idx[2] <= IW'(2);
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            r_v0 <= w_issue;
            r_m0 <= (r_state == S_APEX);
            r_i0 <= r_i;
            r_j0 <= r_j;

            r_v1 <= r_v0;
            r_m1 <= r_m0;
            r_i1 <= r_i0;
            r_j1 <= r_j0;
            r_s1 <= (i_rd_data == r_a) || (i_rd_data == r_b);
            r_a1 <= w_a1;
            r_b1 <= w_b1;
            r_a2 <= w_a2;
            r_b2 <= w_b2;

            r_v2 <= r_v1;
            r_m2 <= r_m1;
            r_i2 <= r_i1;
            r_j2 <= r_j1;
            r_s2 <= r_s1;
            r_p1 <= r_a1 * r_b1;
            r_p2 <= r_a2 * r_b2;

            r_v3   <= r_v2;
            r_m3   <= r_m2;
            r_i3   <= r_i2;
            r_j3   <= r_j2;
            r_s3   <= r_s2;
            r_val3 <= w_val;

            // keep the first strict maximum
            if (r_v3) begin
                if (!r_m3) begin
                    if (r_val3 > r_best) begin
                        r_best   <= r_val3;
                        r_idx[0] <= r_i3;
                        r_idx[1] <= r_j3;
                    end
                end else if (!r_s3 && (r_val3 > r_best)) begin
                    r_best   <= r_val3;
                    r_idx[2] <= r_i3;
                end
            end

            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_n      <= i_job.count;
                        r_few    <= i_job.few;
                        r_idx[0] <= IW'(0);
                        r_idx[1] <= IW'(1);
                        r_idx[2] <= IW'(2);
                        r_best   <= '0;
                        r_i      <= '0;
                        r_k      <= fsap_pkg::ROLE_A;
                    end
                end
                S_GETI: begin
                    r_pi <= i_rd_data;
                    r_j  <= r_i + IW'(1);
                end
                S_PAIR: begin
                    r_j <= r_j + IW'(1);
                    if (w_last_j) begin
                        r_i <= r_i + IW'(1);
                    end
                end
                S_GETA: r_a <= i_rd_data;
                S_GETB: begin
                    r_b    <= i_rd_data;
                    r_best <= '0;
                    r_i    <= '0;
                end
                S_APEX: r_i <= r_i + IW'(1);
                S_EOUT: begin
                    if (w_out_free) begin
                        r_ov     <= 1'b1;
                        r_o_role <= r_k;
                        r_o_idx  <= r_idx[r_k];
                        r_o_x    <= w_in_set ? i_rd_data[2*CW-1:CW] : '0;
                        r_o_y    <= w_in_set ? i_rd_data[CW-1:0] : '0;
                        r_o_few  <= r_few;
                        r_o_last <= (r_k == fsap_pkg::ROLE_APEX);
                        if (r_k == fsap_pkg::ROLE_APEX) begin
                            r_done <= 1'b1;
                        end else begin
                            r_k <= r_k + fsap_pkg::ROLE_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_out_valid   = r_ov;
    assign o_role        = r_o_role;
    assign o_point_index = r_o_idx;
    assign o_out_x       = r_o_x;
    assign o_out_y       = r_o_y;
    assign o_too_few     = r_o_few;
    assign o_last_result = r_o_last;

endmodule

FILE: tb/farthest_pair_and_apex_test.sv
// Self-checking bench for farthest_pair_and_apex: feeds point sets, predicts the pair and apex.
// Depends on fsap_pkg and the RTL top level; needs nothing else.
module farthest_pair_and_apex_test;

    localparam int CW   = fsap_pkg::COORD_W;
    localparam int RW   = fsap_pkg::ROLE_W;
    localparam int IW   = fsap_pkg::IDX_W;
    localparam int NPTS = fsap_pkg::MAX_POINTS;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    // longest correct quiet stretch is a 40-point search behind a long hold
    localparam int STALL_LIMIT  = 20_000;

    localparam logic [CW-1:0] EXTREMES [7] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
    };

    typedef enum int {
        SET_WIDE, SET_NARROW, SET_LINE, SET_REPEAT, SET_EXTREME
    } t_set_shape;

    typedef struct {
        logic [RW-1:0] role;
        logic [IW-1:0] index;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          few;
        logic          last;
    } t_pick;

    class t_pair_apex_board;
        longint pt_x [NPTS];
        longint pt_y [NPTS];
        int     n_loaded;
        t_pick  picks_due [$];
        int     mismatches;

        function void take_point(logic [CW-1:0] x, logic [CW-1:0] y, logic fin);
            longint d, best_d, h, best_h, ax, ay, bx, by, dx, dy;
            int     pick_idx [3];
            bit     few;
            t_pick  p;
            // drop points once the store is full
            if (n_loaded < NPTS) begin
                pt_x[n_loaded] = longint'(signed'(x));
                pt_y[n_loaded] = longint'(signed'(y));
                n_loaded++;
            end
            if (!fin) return;
            few = n_loaded < 3;
            pick_idx = '{0, 1, 2};
            if (!few) begin
                best_d = 0;
                for (int i = 0; i < n_loaded; i++) begin
                    for (int j = i + 1; j < n_loaded; j++) begin
                        dx = pt_x[i] - pt_x[j];
                        dy = pt_y[i] - pt_y[j];
                        d  = dx * dx + dy * dy;
                        if (d > best_d) begin
                            best_d      = d;
                            pick_idx[0] = i;
                            pick_idx[1] = j;
                        end
                    end
                end
                ax = pt_x[pick_idx[0]];
                ay = pt_y[pick_idx[0]];
                bx = pt_x[pick_idx[1]];
                by = pt_y[pick_idx[1]];
                best_h = 0;
                for (int i = 0; i < n_loaded; i++) begin
                    // skip copies of either pair point
                    if (!((pt_x[i] == ax && pt_y[i] == ay) ||
                          (pt_x[i] == bx && pt_y[i] == by))) begin
                        h = (bx - ax) * (pt_y[i] - ay) - (by - ay) * (pt_x[i] - ax);
                        if (h < 0) h = -h;
                        if (h > best_h) begin
                            best_h      = h;
                            pick_idx[2] = i;
                        end
                    end
                end
            end
            for (int k = 0; k < 3; k++) begin
                p.role  = (k == 0) ? fsap_pkg::ROLE_A :
                          (k == 1) ? fsap_pkg::ROLE_B : fsap_pkg::ROLE_APEX;
                p.index = IW'(pick_idx[k]);
                if (pick_idx[k] < n_loaded) begin
                    p.x = CW'(pt_x[pick_idx[k]]);
                    p.y = CW'(pt_y[pick_idx[k]]);
                end else begin
                    p.x = '0;
                    p.y = '0;
                end
                p.few  = few;
                p.last = (k == 2);
                picks_due = {picks_due, p};
            end
            n_loaded = 0;
        endfunction

        function void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pick(logic [RW-1:0] role, logic [IW-1:0] index,
                                 logic [CW-1:0] x, logic [CW-1:0] y,
                                 logic few, logic last);
            t_pick p;
            if (picks_due.size() == 0) begin
                $error("result word with nothing expected: role %0d index %0d", role, index);
                mismatches++;
                return;
            end
            p = picks_due.pop_front();
            check_field("role", CW'(p.role), CW'(role));
            check_field("point_index", CW'(p.index), CW'(index));
            check_field("out_x", p.x, x);
            check_field("out_y", p.y, y);
            check_field("too_few", CW'(p.few), CW'(few));
            check_field("last_result", CW'(p.last), CW'(last));
        endfunction

        function int due();
            return picks_due.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [CW-1:0] i_x_coord;
    logic [CW-1:0] i_y_coord;
    logic          i_final_point;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [RW-1:0] o_role;
    logic [IW-1:0] o_point_index;
    logic [CW-1:0] o_out_x;
    logic [CW-1:0] o_out_y;
    logic          o_too_few;
    logic          o_last_result;

    t_pair_apex_board board;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_req;

    farthest_pair_and_apex u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_final_point (i_final_point),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_role        (o_role),
        .o_point_index (o_point_index),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_too_few     (o_too_few),
        .o_last_result (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_final_point <= fin;
        do @(posedge i_clk); while (o_in_stall);
        board.take_point(x, y, fin);
    endtask

    task automatic send_set(input int n, input t_set_shape shape);
        logic [CW-1:0] base_x, base_y, step_x, step_y, x, y;
        logic [CW-1:0] pool_x [3];
        logic [CW-1:0] pool_y [3];
        int            k;
        base_x = CW'($urandom);
        base_y = CW'($urandom);
        step_x = CW'(int'($urandom_range(0, 6)) - 3);
        step_y = CW'(int'($urandom_range(0, 6)) - 3);
        for (int i = 0; i < 3; i++) begin
            pool_x[i] = CW'($urandom);
            pool_y[i] = CW'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            case (shape)
                SET_WIDE: begin
                    x = CW'($urandom);
                    y = CW'($urandom);
                end
                SET_NARROW: begin
                    x = base_x + CW'(int'($urandom_range(0, 6)) - 3);
                    y = base_y + CW'(int'($urandom_range(0, 6)) - 3);
                end
                SET_LINE: begin
                    k = int'($urandom_range(0, 20));
                    x = base_x + CW'(k) * step_x;
                    y = base_y + CW'(k) * step_y;
                end
                SET_REPEAT: begin
                    k = int'($urandom_range(0, 2));
                    x = pool_x[k];
                    y = pool_y[k];
                end
                default: begin
                    x = EXTREMES[$urandom_range(0, 6)];
                    y = EXTREMES[$urandom_range(0, 6)];
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic run_sets(input int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40)) :
                                              int'($urandom_range(1, 12));
            send_set(n, t_set_shape'($urandom_range(0, 4)));
            sent += n;
        end
    endtask

    // receiver: check each accepted word, then pick the next stall
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                board.check_pick(o_role, o_point_index, o_out_x, o_out_y,
                                 o_too_few, o_last_result);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req && !hold_taken) begin
                hold_taken  = 1'b1;
                hold_left   = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        board         = new;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_final_point = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 86;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone point, then a pair at opposite corners: both too few
        send_point(16'h8000, 16'h7FFF, 1'b1);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b1);
        // identical points: no strict maximum, defaults stand
        for (int i = 0; i < 3; i++) send_point(16'd5, 16'd5, i == 2);
        // collinear points: apex height never leaves zero
        for (int i = 0; i < 4; i++) send_point(CW'(i), CW'(-2 * i), i == 3);
        // corners with a copy of pair point A and tied diagonals
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b0);
        send_point(16'h7FFF, 16'h8000, 1'b1);
        // unit square: ties keep the first strict maximum
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd1, 16'd0, 1'b0);
        send_point(16'd0, 16'd1, 1'b0);
        send_point(16'd1, 16'd1, 1'b1);

        run_sets(90);
        send_idle_pct = 86;
        recv_idle_pct = 21;
        run_sets(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold the output while sets keep arriving, so the input backs up
        hold_req = 1'b1;
        run_sets(70);
        i_in_valid <= 1'b0;

        while (board.due() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
